// ----- design/lsfe_pkg.sv -----
// Shared types, constants and the bit-to-code encoder for the LED strip frame encoder.
// No dependencies; used by every module of the block.
package lsfe_pkg;

    localparam int LED_MAX     = 16;
    localparam int IDX_W       = (LED_MAX > 1) ? $clog2(LED_MAX) : 1;
    localparam int COUNT_W     = 5;
    localparam int CODE_W      = 8;
    localparam int COLOUR_W    = 24;
    localparam int INDEX_W     = 16;
    localparam int WORD_W      = 64;
    localparam int DIV_STEPS   = INDEX_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_FILL = 2'd1;
    localparam logic [1:0] OP_SEND = 2'd2;

    localparam logic [1:0] CFG_LED_COUNT = 2'd0;
    localparam logic [1:0] CFG_CODE_ZERO = 2'd1;
    localparam logic [1:0] CFG_CODE_ONE  = 2'd2;

    localparam logic [COUNT_W-1:0] LED_COUNT_RESET = 5'd10;
    localparam logic [CODE_W-1:0]  CODE_ZERO_RESET = 8'h40;
    localparam logic [CODE_W-1:0]  CODE_ONE_RESET  = 8'h70;

    // trailer: three zero words, the last one flagged
    localparam logic [1:0] TRAIL_LAST = 2'd2;
    localparam logic [1:0] CHAN_LAST  = 2'd2;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [COLOUR_W-1:0] data;
    } lsfe_wr_t;

    typedef struct packed {
        logic               start;
        logic               neg;
        logic [INDEX_W-1:0] mag;
        logic [COUNT_W-1:0] divisor;
    } lsfe_div_req_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] index;
    } lsfe_div_rsp_t;

    function automatic logic [WORD_W-1:0] encode_byte(
        input logic [7:0]        chan,
        input logic [CODE_W-1:0] zero,
        input logic [CODE_W-1:0] one
    );
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
        begin
            w[i*8 +: 8] = chan[i] ? one : zero;
        end
        return w;
    endfunction

endpackage

// ----- design/led_strip_spi_frame_encoder.sv -----
// LED strip SPI frame encoder: top level with the op sequencer and output register.
// Depends on lsfe_pkg, lsfe_mod_unit and lsfe_store.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one op per beat: set one LED (op 0),
//   fill all LEDs (op 1) or send a frame (op 2). in_stall is high while an op runs.
//   Output channel (out_valid / out_stall) carries 64-bit SPI code words, one per
//   colour byte (green, red, blue per LED), then three zero words; the last is
//   flagged by last_of_frame. A held word stays put while out_stall is high.
//   Config channel (cfg_valid / cfg_ready) is always ready; write only when idle.
// Timing (n = led_count saturated to 16):
//   set:  accept, then 16 remainder steps, then the store write.
//   fill: n store writes after accept, one store write per cycle.
//   send: 3n + 3 words, one per cycle when not stalled, as are the store read and
//         encode; accept enters ST_SEND, which loads the first word into word_reg.
// Reset clears the store to zero and restores led_count 10, codes 0x40 / 0x70.
module led_strip_spi_frame_encoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       op,
    input  logic signed [15:0]               led_index,
    input  logic [23:0]                      colour_grb,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [63:0]                      code_word,
    output logic                             last_of_frame,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [7:0]                       cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_FILL  = 3'd2;
    localparam logic [2:0] ST_SEND  = 3'd3;
    localparam logic [2:0] ST_TRAIL = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [lsfe_pkg::COUNT_W-1:0]       led_count_reg;
    logic [lsfe_pkg::CODE_W-1:0]        code_zero_reg;
    logic [lsfe_pkg::CODE_W-1:0]        code_one_reg;
    logic [lsfe_pkg::COLOUR_W-1:0]      colour_reg, colour_next;
    logic [lsfe_pkg::IDX_W-1:0]         led_cnt_reg, led_cnt_next;
    logic [1:0]                         chan_reg, chan_next;
    logic [1:0]                         trail_reg, trail_next;
    logic                               out_valid_reg, out_valid_next;
    logic [lsfe_pkg::WORD_W-1:0]        word_reg, word_next;
    logic                               last_reg, last_next;

    logic [lsfe_pkg::COUNT_W-1:0]       eff_n;
    logic                               at_last_led;
    logic                               in_take;
    logic                               load_ok;
    logic [lsfe_pkg::COLOUR_W-1:0]      rd_data;
    logic [7:0]                         chan_byte;
    lsfe_pkg::lsfe_wr_t                 wr;
    lsfe_pkg::lsfe_div_req_t            div_req;
    lsfe_pkg::lsfe_div_rsp_t            div_rsp;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= lsfe_pkg::LED_COUNT_RESET;
            code_zero_reg <= lsfe_pkg::CODE_ZERO_RESET;
            code_one_reg  <= lsfe_pkg::CODE_ONE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lsfe_pkg::CFG_LED_COUNT: led_count_reg <= cfg_data[lsfe_pkg::COUNT_W-1:0];
                lsfe_pkg::CFG_CODE_ZERO: code_zero_reg <= cfg_data;
                lsfe_pkg::CFG_CODE_ONE:  code_one_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_n = (led_count_reg > lsfe_pkg::COUNT_W'(lsfe_pkg::LED_MAX)) ?
                   lsfe_pkg::COUNT_W'(lsfe_pkg::LED_MAX) : led_count_reg;
    assign at_last_led = (lsfe_pkg::COUNT_W'(led_cnt_reg) == eff_n - 1'b1);

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign load_ok  = !out_valid_reg || !out_stall;

    assign div_req.start   = in_take && (op == lsfe_pkg::OP_SET) && (eff_n != '0);
    assign div_req.neg     = led_index[15];
    assign div_req.mag     = led_index[15] ? 16'(-led_index) : 16'(led_index);
    assign div_req.divisor = eff_n;

    lsfe_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        wr.en   = 1'b0;
        wr.addr = led_cnt_reg;
        wr.data = colour_reg;
        if (state_reg == ST_DIV && div_rsp.done)
        begin
            wr.en   = 1'b1;
            wr.addr = div_rsp.index;
        end
        else if (state_reg == ST_FILL)
        begin
            wr.en = 1'b1;
        end
    end

    lsfe_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (led_cnt_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (chan_reg)
            2'd0:    chan_byte = rd_data[23:16];
            2'd1:    chan_byte = rd_data[15:8];
            default: chan_byte = rd_data[7:0];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        colour_next    = colour_reg;
        led_cnt_next   = led_cnt_reg;
        chan_next      = chan_reg;
        trail_next     = trail_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        last_next      = last_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    colour_next  = colour_grb;
                    led_cnt_next = '0;
                    chan_next    = '0;
                    trail_next   = '0;
                    case (op)
                        lsfe_pkg::OP_SET:  state_next = (eff_n != '0) ? ST_DIV : ST_IDLE;
                        lsfe_pkg::OP_FILL: state_next = (eff_n != '0) ? ST_FILL : ST_IDLE;
                        lsfe_pkg::OP_SEND: state_next = (eff_n != '0) ? ST_SEND : ST_TRAIL;
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_IDLE;
            end
            ST_FILL:
            begin
                led_cnt_next = led_cnt_reg + 1'b1;
                if (at_last_led)
                    state_next = ST_IDLE;
            end
            ST_SEND:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    word_next = lsfe_pkg::encode_byte(chan_byte, code_zero_reg, code_one_reg);
                    last_next = 1'b0;
                    chan_next = chan_reg + 1'b1;
                    if (chan_reg == lsfe_pkg::CHAN_LAST)
                    begin
                        chan_next    = '0;
                        led_cnt_next = led_cnt_reg + 1'b1;
                        if (at_last_led)
                            state_next = ST_TRAIL;
                    end
                end
            end
            ST_TRAIL:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    word_next      = '0;
                    last_next      = (trail_reg == lsfe_pkg::TRAIL_LAST);
                    trail_next     = trail_reg + 1'b1;
                    if (trail_reg == lsfe_pkg::TRAIL_LAST)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            led_cnt_reg   <= '0;
            chan_reg      <= '0;
            trail_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            led_cnt_reg   <= led_cnt_next;
            chan_reg      <= chan_next;
            trail_reg     <= trail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        colour_reg <= colour_next;
        word_reg   <= word_next;
        last_reg   <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign code_word     = word_reg;
    assign last_of_frame = last_reg;

`ifndef ASSERT_OFF
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("remainder result outside set sequence");

    a_send_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEND |-> lsfe_pkg::COUNT_W'(led_cnt_reg) < eff_n)
        else $error("send walked past the LED count");

    a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> word_reg == '0)
        else $error("flagged word is not a trailer word");

    a_trail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TRAIL |-> trail_reg <= lsfe_pkg::TRAIL_LAST)
        else $error("trailer count overrun");
`endif

endmodule

// ----- design/lsfe_mod_unit.sv -----
// Iterative signed-index reduction: restoring remainder, one dividend bit per cycle.
// Depends on lsfe_pkg.
module lsfe_mod_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lsfe_pkg::lsfe_div_req_t req,
    output lsfe_pkg::lsfe_div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic                           neg_reg, neg_next;
    logic [lsfe_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [lsfe_pkg::INDEX_W-1:0]   dvd_reg, dvd_next;
    logic [lsfe_pkg::IDX_W-1:0]     rem_reg, rem_next;
    logic [lsfe_pkg::COUNT_W-1:0]   div_reg, div_next;
    logic [lsfe_pkg::IDX_W:0]       trial;
    logic [lsfe_pkg::COUNT_W-1:0]   wrapped;

    assign trial = {rem_reg, dvd_reg[lsfe_pkg::INDEX_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next  = req.neg;
            step_next = '0;
            dvd_next  = req.mag;
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shared compare-subtract step
            if (trial >= (lsfe_pkg::IDX_W + 1)'(div_reg))
                rem_next = lsfe_pkg::IDX_W'(trial - (lsfe_pkg::IDX_W + 1)'(div_reg));
            else
                rem_next = trial[lsfe_pkg::IDX_W-1:0];
            dvd_next  = {dvd_reg[lsfe_pkg::INDEX_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == lsfe_pkg::STEP_W'(lsfe_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    // truncating remainder of a negative index counts back from the end
    assign wrapped   = div_reg - lsfe_pkg::COUNT_W'(rem_reg);
    assign rsp.done  = done_reg;
    assign rsp.index = (neg_reg && rem_reg != '0) ? wrapped[lsfe_pkg::IDX_W-1:0] : rem_reg;

endmodule

// ----- design/lsfe_store.sv -----
// Colour store: one 24-bit GRB entry per LED, cleared to zero at reset.
// One write port, one combinational read port. Depends on lsfe_pkg.
module lsfe_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lsfe_pkg::lsfe_wr_t              wr,
    input  logic [lsfe_pkg::IDX_W-1:0]      rd_addr,
    output logic [lsfe_pkg::COLOUR_W-1:0]   rd_data
);

    logic [lsfe_pkg::COLOUR_W-1:0] entry_reg [lsfe_pkg::LED_MAX];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lsfe_pkg::LED_MAX; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            entry_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = entry_reg[rd_addr];

endmodule
